/* src/grid_window_3x3_packer_unit_defines.svh */
// assertion macros shared by the grid window packer rtl
`ifndef GRID_WINDOW_3X3_PACKER_UNIT_DEFINES_SVH
`define GRID_WINDOW_3X3_PACKER_UNIT_DEFINES_SVH

// condition that holds at every clock edge outside reset
`define GW3_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GW3_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/gw3_pkg.sv */
// shared types and constants of the grid window packer
package gw3_pkg;

	localparam int MAT_W      = 4;
	localparam int WIN_SIZE   = 9;
	localparam int COORD_W    = 10;
	localparam int EMPTY_W    = 2 * WIN_SIZE;
	localparam int MATW_W     = MAT_W * WIN_SIZE;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	localparam logic REQ_CELL = 1'b0;
	localparam logic REQ_PAD  = 1'b1;

	typedef struct packed {
		logic             wall;
		logic             empty;
		logic [MAT_W-1:0] material;
	} gw3_cell_t;

	typedef gw3_cell_t [WIN_SIZE-1:0] gw3_win_t;

	typedef struct packed {
		gw3_cell_t upper;
		gw3_cell_t middle;
	} gw3_lb_word_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic first_col;
	} gw3_win_ctl_t;

endpackage

/* src/gw3_if.sv */
// stream interfaces for grid cells and packed windows
interface gw3_in_if import gw3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [MAT_W-1:0] cell_material;
	logic             cell_empty;
	logic             cell_wall;

	modport source(output valid, req_type, cell_material, cell_empty, cell_wall, input ready);
	modport sink(input valid, req_type, cell_material, cell_empty, cell_wall, output ready);
endinterface

interface gw3_out_if import gw3_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] center_x;
	logic [COORD_W-1:0] center_y;
	logic [EMPTY_W-1:0] empty_window;
	logic [MATW_W-1:0]  material_window;
	logic               center_empty;
	logic               center_wall;
	logic               frame_last;

	modport source(output valid, center_x, center_y, empty_window, material_window,
		center_empty, center_wall, frame_last, input ready);
	modport sink(input valid, center_x, center_y, empty_window, material_window,
		center_empty, center_wall, frame_last, output ready);
endinterface

/* src/gw3_window.sv */
// 3x3 sliding register window with zero-column insertion at row start
module gw3_window import gw3_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  gw3_win_ctl_t ctl,
	input  gw3_cell_t    top,
	input  gw3_cell_t    mid,
	input  gw3_cell_t    bot,
	output gw3_win_t     view
);

	gw3_win_t win_q;
	gw3_win_t pre;
	gw3_win_t nxt;

	function automatic gw3_win_t slide(gw3_win_t w, gw3_cell_t t, gw3_cell_t m, gw3_cell_t b);
		gw3_win_t r;
		r    = w;
		r[0] = w[1];
		r[1] = w[2];
		r[3] = w[4];
		r[4] = w[5];
		r[6] = w[7];
		r[7] = w[8];
		r[2] = t;
		r[5] = m;
		r[8] = b;
		return r;
	endfunction

	always_comb begin
		if (ctl.first_col) begin
			pre = slide(win_q, '0, '0, '0);
			nxt = slide(pre, top, mid, bot);
		end else begin
			pre = slide(win_q, top, mid, bot);
			nxt = pre;
		end
	end

	assign view = pre;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.clear) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= nxt;
		end
	end

endmodule

/* src/grid_window_3x3_packer_unit.sv */
// top level of the 3x3 grid window packer
//
//  channel   | dir  | transaction
//  cells     | sink | one grid cell or pad item in raster order
//  windows   | src  | one packed 3x3 window with its center position
//  cfg_*     | sink | register write, index 0 grid width, index 1 grid height
//
// one transaction per cycle on cells unless the second stage stalls or cfg_we is high; the line
// buffer is one memory with a registered read, written back by the stage after the read
// a window is packed in the second stage from the cell that completes it, then registered at the output
// back-to-back reuse of one column (width one) is served by forwarding the last write
// a stalled output holds an emitting second stage; reset clears control, not the line buffer
`include "grid_window_3x3_packer_unit_defines.svh"

module grid_window_3x3_packer_unit import gw3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	gw3_in_if.sink                cells,
	gw3_out_if.source             windows
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int DW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 3);
	localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

	function automatic logic [15:0] clamp_dim(logic [CFG_DATA_W-1:0] v, logic [15:0] maxv);
		logic [15:0] d;
		d = 16'(v);
		if (d == 16'd0) d = 16'd1;
		if (d > maxv) d = maxv;
		return d;
	endfunction

	logic [DW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [AW:0]   w_a;
	logic [RW-1:0] h_r;

	logic          accept;
	logic          pad;
	logic          row_ge_h;
	logic          drained;
	logic          active;
	logic          load_s1;
	logic [AW-1:0] col_e;
	logic [RW-1:0] row_e;
	logic [AW-1:0] col_eff;
	logic [AW:0]   col_inc;
	logic          wrap;
	logic [AW-1:0] col_nx;
	logic [RW-1:0] row_nx;
	gw3_cell_t     data_s0;

	gw3_lb_word_t  lb_mem [MAX_WIDTH];
	gw3_lb_word_t  rd_q;
	gw3_lb_word_t  wr_q;
	gw3_lb_word_t  src_word;
	gw3_lb_word_t  wr_word;

	logic          s1_valid_q;
	logic [AW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	gw3_cell_t     data_s1;
	logic          fwd_s1;

	logic          s1_go;
	logic          s1_emit;
	logic          col0;
	logic [AW-1:0] cx;
	logic [RW-1:0] cy;
	logic [2:0]    xok;
	logic [2:0]    yok;
	logic [EMPTY_W-1:0] ew;
	logic [MATW_W-1:0]  mw;
	logic          last;

	gw3_win_ctl_t  win_ctl;
	gw3_win_t      view;

	logic               out_valid_q;
	logic [COORD_W-1:0] center_x_q;
	logic [COORD_W-1:0] center_y_q;
	logic [EMPTY_W-1:0] empty_window_q;
	logic [MATW_W-1:0]  material_window_q;
	logic               center_empty_q;
	logic               center_wall_q;
	logic               frame_last_q;

	assign w_a = (AW + 1)'(w_q);
	assign h_r = RW'(h_q);

	// input stage: position tracking and line buffer read
	assign cells.ready = (!s1_valid_q || s1_go) && !cfg_we;
	assign accept      = cells.valid && cells.ready;
	assign pad         = (cells.req_type == REQ_PAD);

	always_comb begin
		row_ge_h = (row_q >= h_r);
		drained  = (row_q > h_r + RW'(1)) || ((row_q == h_r + RW'(1)) && (col_q != '0));
		active   = pad ? (row_ge_h && !drained) : 1'b1;
		if (!pad && row_ge_h) begin
			col_e = '0;
			row_e = '0;
		end else begin
			col_e = col_q;
			row_e = row_q;
		end
		col_eff = ({1'b0, col_e} >= w_a) ? '0 : col_e;
		col_inc = {1'b0, col_eff} + (AW + 1)'(1);
		wrap    = (col_inc >= w_a);
		col_nx  = wrap ? '0 : col_inc[AW-1:0];
		row_nx  = wrap ? row_e + RW'(1) : row_e;
		if (pad) begin
			data_s0 = '0;
		end else begin
			data_s0.wall     = cells.cell_wall;
			data_s0.empty    = cells.cell_empty;
			data_s0.material = cells.cell_material;
		end
	end

	assign load_s1 = accept && active;

	// second stage: write back, slide and pack
	assign src_word       = fwd_s1 ? wr_q : rd_q;
	assign wr_word.upper  = src_word.middle;
	assign wr_word.middle = data_s1;

	assign col0    = (col_s1 == '0);
	assign s1_emit = col0 ? (row_s1 >= RW'(2)) : ((row_s1 >= RW'(1)) && (row_s1 <= h_r));
	assign s1_go   = s1_valid_q && (!s1_emit || !out_valid_q || windows.ready);

	assign win_ctl.shift     = s1_go;
	assign win_ctl.clear     = cfg_we;
	assign win_ctl.first_col = col0;

	gw3_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.top    (src_word.upper),
		.mid    (src_word.middle),
		.bot    (data_s1),
		.view   (view)
	);

	always_comb begin
		cx = col0 ? AW'(w_q - DW'(1)) : col_s1 - AW'(1);
		cy = col0 ? row_s1 - RW'(2) : row_s1 - RW'(1);
		xok[0] = (cx != '0);
		xok[1] = 1'b1;
		xok[2] = ({1'b0, cx} + (AW + 1)'(1)) < w_a;
		yok[0] = (cy != '0) && (cy <= h_r);
		yok[1] = (cy < h_r);
		yok[2] = (cy + RW'(1)) < h_r;
		ew = '0;
		mw = '0;
		for (int k = 0; k < WIN_SIZE; k++) begin
			if (yok[k / 3] && xok[k % 3]) begin
				ew[WIN_SIZE + k]   = 1'b1;
				ew[k]              = view[k].empty;
				mw[k * MAT_W +: MAT_W] = view[k].material;
			end
		end
		last = ({1'b0, cx} == w_a - (AW + 1)'(1)) && (cy == h_r - RW'(1));
	end

	// line buffer memory
	always_ff @(posedge clk) begin
		if (load_s1) begin
			rd_q <= lb_mem[col_eff];
		end
		if (s1_go) begin
			lb_mem[col_s1] <= wr_word;
			wr_q           <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			col_s1  <= col_eff;
			row_s1  <= row_e;
			data_s1 <= data_s0;
			fwd_s1  <= s1_go && (col_s1 == col_eff);
		end
		if (s1_go && s1_emit) begin
			center_x_q        <= COORD_W'(cx);
			center_y_q        <= COORD_W'(cy);
			empty_window_q    <= ew;
			material_window_q <= mw;
			center_empty_q    <= view[4].empty;
			center_wall_q     <= view[4].wall;
			frame_last_q      <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= DW'(W_RST);
			h_q         <= HW'(H_RST);
			col_q       <= '0;
			row_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH: begin
					w_q <= DW'(clamp_dim(cfg_wdata, 16'(MAX_WIDTH)));
				end
				CFG_GRID_HEIGHT: begin
					h_q <= HW'(clamp_dim(cfg_wdata, 16'(MAX_HEIGHT)));
				end
				default: begin
				end
			endcase
			col_q       <= '0;
			row_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				col_q <= col_nx;
				row_q <= row_nx;
			end
			if (load_s1) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go && s1_emit) begin
				out_valid_q <= 1'b1;
			end else if (windows.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign windows.valid           = out_valid_q;
	assign windows.center_x        = center_x_q;
	assign windows.center_y        = center_y_q;
	assign windows.empty_window    = empty_window_q;
	assign windows.material_window = material_window_q;
	assign windows.center_empty    = center_empty_q;
	assign windows.center_wall     = center_wall_q;
	assign windows.frame_last      = frame_last_q;

	`GW3_ASSERT_ALWAYS(a_row_bound, row_q <= h_r + RW'(2), "row counter past drain end")
	`GW3_ASSERT_IMPLY(a_s1_col_range, s1_valid_q, {1'b0, col_s1} < w_a, "column beyond width")
	`GW3_ASSERT_IMPLY(a_last_pos, out_valid_q && frame_last_q,
		(center_x_q == COORD_W'(w_q - DW'(1))) && (center_y_q == COORD_W'(h_q - HW'(1))),
		"frame end flagged off the last cell")

endmodule
